### sv/wfcrb_pkg.sv
// ----------------------------------------------------------------------------
// wfcrb_pkg
// Shared types and constants for the watermark flow control receive buffer.
// ----------------------------------------------------------------------------
package wfcrb_pkg;

  localparam int unsigned CFG_W    = 9;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned FBLVL_W  = 7;
  localparam int unsigned CIDX_W   = 2;

  typedef enum logic [1:0] {
    OP_ARRIVE     = 2'd0,
    OP_SERVE_DATA = 2'd1,
    OP_SERVE_FB   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_DROPPED     = 3'd1,
    ST_DATA_OUT    = 3'd2,
    ST_FB_OUT      = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_FB_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_STOP   = 2'd1,
    EMIT_RESUME = 2'd2
  } emit_t;

  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd3;

  localparam logic [CIDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HIGH_MARK = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LOW_MARK  = 2'd2;

  localparam logic [CFG_W-1:0] CAPACITY_RESET  = 9'd200;
  localparam logic [CFG_W-1:0] HIGH_MARK_RESET = 9'd150;
  localparam logic [CFG_W-1:0] LOW_MARK_RESET  = 9'd90;

endpackage

### sv/watermark_flow_control_rx_buffer.sv
// ----------------------------------------------------------------------------
// watermark_flow_control_rx_buffer
// Receive buffer with a data queue and a feedback queue held in synchronous
// memories, and stop/resume flow control driven by occupancy watermarks.
// ----------------------------------------------------------------------------
// Latency: the result of a command appears on the result ports, marked by
// done, in the cycle after the command is taken.
// Throughput: one command per cycle while busy is low; each command makes at most one queue access.
// Reset: synchronous; counts, heads and the throttle flag clear, the registers
// return to 200/150/90, and busy is high for one cycle after reset.
// The receiver cannot stall; results are never held.
module watermark_flow_control_rx_buffer #(
  parameter int unsigned DATA_DEPTH     = 256,
  parameter int unsigned FEEDBACK_DEPTH = 64,
  parameter int unsigned TAG_BITS       = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [wfcrb_pkg::TAG_W-1:0]     packet_tag,
  input  logic [wfcrb_pkg::KIND_W-1:0]    packet_kind,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wfcrb_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [wfcrb_pkg::CFG_W-1:0]     cfg_data,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [1:0]                      control_emit,
  output logic [wfcrb_pkg::TAG_W-1:0]     out_tag,
  output logic [wfcrb_pkg::KIND_W-1:0]    out_kind,
  output logic [wfcrb_pkg::LEVEL_W-1:0]   data_level,
  output logic [wfcrb_pkg::FBLVL_W-1:0]   feedback_level
);

  localparam int unsigned DAW   = $clog2(DATA_DEPTH);
  localparam int unsigned DCW   = $clog2(DATA_DEPTH + 1);
  localparam int unsigned FAW   = $clog2(FEEDBACK_DEPTH);
  localparam int unsigned FCW   = $clog2(FEEDBACK_DEPTH + 1);
  localparam int unsigned CMP_W = (DCW > wfcrb_pkg::CFG_W) ? DCW : wfcrb_pkg::CFG_W;
  localparam int unsigned ENT_W = TAG_BITS + wfcrb_pkg::KIND_W;
  localparam int unsigned XW    = TAG_BITS + wfcrb_pkg::TAG_W;

  logic [wfcrb_pkg::CFG_W-1:0] capacity;
  logic [wfcrb_pkg::CFG_W-1:0] high_mark;
  logic [wfcrb_pkg::CFG_W-1:0] low_mark;

  logic [ENT_W-1:0] dq_mem [DATA_DEPTH];
  logic [ENT_W-1:0] fb_mem [FEEDBACK_DEPTH];
  logic [ENT_W-1:0] dq_rd;
  logic [ENT_W-1:0] fb_rd;

  logic [DCW-1:0] data_count, data_count_next;
  logic [DAW-1:0] data_head, data_head_next;
  logic [FCW-1:0] fb_count, fb_count_next;
  logic [FAW-1:0] fb_head, fb_head_next;
  logic           throttled, throttled_next;

  wfcrb_pkg::status_t status_q, status_next;
  wfcrb_pkg::emit_t   emit_q, emit_next;

  logic           accept;
  logic           dq_we, dq_re, fb_we, fb_re;
  logic [DCW:0]   dq_sum, dq_wrap;
  logic [DAW-1:0] dq_tail;
  logic [FCW:0]   fb_sum, fb_wrap;
  logic [FAW-1:0] fb_tail;
  logic [CMP_W-1:0] count_cmp, cap_cmp, high_cmp, low_cmp;
  logic [XW-1:0]  tag_in_x;
  logic [XW-1:0]  tag_out_x;
  logic [ENT_W-1:0] wr_entry;
  logic [ENT_W-1:0] rd_entry;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign tag_in_x = {{TAG_BITS{1'b0}}, packet_tag};
  assign wr_entry = {tag_in_x[TAG_BITS-1:0], packet_kind};

  assign dq_sum  = (DCW+1)'(data_head) + (DCW+1)'(data_count);
  assign dq_wrap = dq_sum - (DCW+1)'(DATA_DEPTH);
  assign dq_tail = (dq_sum >= (DCW+1)'(DATA_DEPTH)) ? dq_wrap[DAW-1:0] : dq_sum[DAW-1:0];
  assign fb_sum  = (FCW+1)'(fb_head) + (FCW+1)'(fb_count);
  assign fb_wrap = fb_sum - (FCW+1)'(FEEDBACK_DEPTH);
  assign fb_tail = (fb_sum >= (FCW+1)'(FEEDBACK_DEPTH)) ? fb_wrap[FAW-1:0] : fb_sum[FAW-1:0];

  assign count_cmp = CMP_W'(data_count);
  assign cap_cmp   = CMP_W'(capacity);
  assign high_cmp  = CMP_W'(high_mark);
  assign low_cmp   = CMP_W'(low_mark);

  always_comb begin
    data_count_next = data_count;
    data_head_next  = data_head;
    fb_count_next   = fb_count;
    fb_head_next    = fb_head;
    throttled_next  = throttled;
    status_next     = wfcrb_pkg::ST_ACCEPTED;
    emit_next       = wfcrb_pkg::EMIT_NONE;
    dq_we           = 1'b0;
    dq_re           = 1'b0;
    fb_we           = 1'b0;
    fb_re           = 1'b0;
    if (accept) begin
      case (opcode)
        wfcrb_pkg::OP_ARRIVE: begin
          if (count_cmp >= cap_cmp || data_count == DCW'(DATA_DEPTH)) begin
            status_next = wfcrb_pkg::ST_DROPPED;
          end else if (packet_kind == wfcrb_pkg::KIND_STOP ||
                       packet_kind == wfcrb_pkg::KIND_RESUME) begin
            if (fb_count == FCW'(FEEDBACK_DEPTH)) begin
              status_next = wfcrb_pkg::ST_FB_OVERFLOW;
            end else begin
              fb_we         = 1'b1;
              fb_count_next = fb_count + 1'b1;
            end
          end else begin
            if (count_cmp >= high_cmp && !throttled) begin
              emit_next      = wfcrb_pkg::EMIT_STOP;
              throttled_next = 1'b1;
            end else if (count_cmp < low_cmp && throttled) begin
              emit_next      = wfcrb_pkg::EMIT_RESUME;
              throttled_next = 1'b0;
            end
            dq_we           = 1'b1;
            data_count_next = data_count + 1'b1;
          end
        end
        wfcrb_pkg::OP_SERVE_DATA: begin
          if (data_count == '0) begin
            status_next = wfcrb_pkg::ST_EMPTY;
          end else begin
            dq_re           = 1'b1;
            status_next     = wfcrb_pkg::ST_DATA_OUT;
            data_count_next = data_count - 1'b1;
            data_head_next  = (data_head == DAW'(DATA_DEPTH - 1)) ? '0 : data_head + 1'b1;
          end
        end
        wfcrb_pkg::OP_SERVE_FB: begin
          if (fb_count == '0) begin
            status_next = wfcrb_pkg::ST_EMPTY;
          end else begin
            fb_re         = 1'b1;
            status_next   = wfcrb_pkg::ST_FB_OUT;
            fb_count_next = fb_count - 1'b1;
            fb_head_next  = (fb_head == FAW'(FEEDBACK_DEPTH - 1)) ? '0 : fb_head + 1'b1;
          end
        end
        default: begin
          status_next = wfcrb_pkg::ST_ACCEPTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      done       <= 1'b0;
      data_count <= '0;
      data_head  <= '0;
      fb_count   <= '0;
      fb_head    <= '0;
      throttled  <= 1'b0;
      status_q   <= wfcrb_pkg::ST_ACCEPTED;
      emit_q     <= wfcrb_pkg::EMIT_NONE;
      capacity   <= wfcrb_pkg::CAPACITY_RESET;
      high_mark  <= wfcrb_pkg::HIGH_MARK_RESET;
      low_mark   <= wfcrb_pkg::LOW_MARK_RESET;
    end else begin
      busy       <= 1'b0;
      done       <= accept;
      data_count <= data_count_next;
      data_head  <= data_head_next;
      fb_count   <= fb_count_next;
      fb_head    <= fb_head_next;
      throttled  <= throttled_next;
      status_q   <= status_next;
      emit_q     <= emit_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wfcrb_pkg::CFG_CAPACITY:  capacity  <= cfg_data;
          wfcrb_pkg::CFG_HIGH_MARK: high_mark <= cfg_data;
          wfcrb_pkg::CFG_LOW_MARK:  low_mark  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dq_we) begin
      dq_mem[dq_tail] <= wr_entry;
    end
    if (dq_re) begin
      dq_rd <= dq_mem[data_head];
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_tail] <= wr_entry;
    end
    if (fb_re) begin
      fb_rd <= fb_mem[fb_head];
    end
  end

  always_comb begin
    case (status_q)
      wfcrb_pkg::ST_DATA_OUT: rd_entry = dq_rd;
      wfcrb_pkg::ST_FB_OUT:   rd_entry = fb_rd;
      default:                rd_entry = '0;
    endcase
  end

  assign tag_out_x      = {{wfcrb_pkg::TAG_W{1'b0}}, rd_entry[ENT_W-1:wfcrb_pkg::KIND_W]};
  assign out_tag        = tag_out_x[wfcrb_pkg::TAG_W-1:0];
  assign out_kind       = rd_entry[wfcrb_pkg::KIND_W-1:0];
  assign status         = status_q;
  assign control_emit   = emit_q;
  assign data_level     = wfcrb_pkg::LEVEL_W'(data_count);
  assign feedback_level = wfcrb_pkg::FBLVL_W'(fb_count);

  // Each result follows exactly one accepted command.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start && !busy))
    else $error("result strobe without a command");

  assert property (@(posedge clk) disable iff (rst) data_count <= DCW'(DATA_DEPTH))
    else $error("data queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst) fb_count <= FCW'(FEEDBACK_DEPTH))
    else $error("feedback queue count beyond depth");

  // Flow control messages only come with a data insert.
  assert property (@(posedge clk) disable iff (rst)
      (emit_q != wfcrb_pkg::EMIT_NONE) |-> (done && status_q == wfcrb_pkg::ST_ACCEPTED))
    else $error("flow control message outside a data insert");

  assert property (@(posedge clk) disable iff (rst)
      $rose(throttled) |-> (done && emit_q == wfcrb_pkg::EMIT_STOP))
    else $error("throttle set without a stop message");

endmodule
